[sv/rtcms_pkg.sv]
// ----------------------------------------------------------------------------
// rtcms_pkg
// shared types and constants for the extended millisecond clock
// ----------------------------------------------------------------------------
package rtcms_pkg;

   // tick rate is 32768 Hz, so one tick is 1000 / 2^15 ms
   localparam int unsigned MS_PER_SEC = 1000;
   localparam int unsigned TICK_SHIFT = 15;
   localparam int unsigned CNT_W      = 32;
   localparam int unsigned TIME_W     = 64;
   localparam int unsigned KIND_W     = 3;
   localparam int unsigned MULT_W     = CNT_W + 10;      // 1000 fits in 10 bits
   localparam int unsigned HI_SHIFT   = CNT_W - TICK_SHIFT;

   typedef enum logic [KIND_W-1:0] {
      REQ_SAMPLE  = 3'd0,
      REQ_READ    = 3'd1,
      REQ_SET     = 3'd2,
      REQ_DISABLE = 3'd3,
      REQ_RESTORE = 3'd4
   } req_kind_type;

   // one request word as it travels between pipeline stages
   typedef struct packed {
      logic [KIND_W-1:0] req_type;
      logic [CNT_W-1:0]  counter_sample;
      logic [TIME_W-1:0] new_time;
   } req_word_type;

endpackage

[sv/rtcms_if.sv]
// ----------------------------------------------------------------------------
// rtcms_if
// valid/ready channels for request and response words
// ----------------------------------------------------------------------------
interface rtcms_req_if
   import rtcms_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] req_type;
   logic [CNT_W-1:0]  counter_sample;
   logic [TIME_W-1:0] new_time;

   modport source (output valid, req_type, counter_sample, new_time, input ready);
   modport sink   (input valid, req_type, counter_sample, new_time, output ready);
endinterface

interface rtcms_rsp_if
   import rtcms_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] time_ms;
   logic              enabled;

   modport source (output valid, time_ms, enabled, input ready);
   modport sink   (input valid, time_ms, enabled, output ready);
endinterface

[sv/rtcms_in_stage.sv]
// ----------------------------------------------------------------------------
// rtcms_in_stage
// input register for request words
// ----------------------------------------------------------------------------
module rtcms_in_stage
   import rtcms_pkg::*;
   (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_word_type in_word,
   output logic         out_valid,
   input  logic         out_ready,
   output req_word_type out_word
   );

   logic         valid_ff, valid_in;
   req_word_type word_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= in_word;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

[sv/rtcms_core.sv]
// ----------------------------------------------------------------------------
// rtcms_core
// clock state, millisecond computation and response register
// ----------------------------------------------------------------------------
module rtcms_core
   import rtcms_pkg::*;
   (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  req_word_type      in_word,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [TIME_W-1:0] out_time_ms,
   output logic              out_enabled
   );

   logic              on_ff, on_in;
   logic [TIME_W-1:0] base_ff, base_in;
   logic [CNT_W-1:0]  wrap_ff, wrap_in;
   logic [CNT_W-1:0]  last_ff, last_in;
   logic              valid_ff, valid_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic              enabled_ff;

   logic              take;
   req_kind_type      kind;
   logic [CNT_W-1:0]  sample_wrap;
   logic [CNT_W-1:0]  wrap_sel;
   logic [CNT_W-1:0]  low_sel;
   logic [MULT_W-1:0] hi_prod;
   logic [MULT_W-1:0] lo_prod;
   logic [TIME_W-1:0] calc_ms;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;
   assign kind     = req_kind_type'(in_word.req_type);

   // high word bumps when the counter went backwards
   assign sample_wrap = (in_word.counter_sample < last_ff) ? wrap_ff + CNT_W'(1) : wrap_ff;

   // read uses the fresh sample, restore the stored one
   assign wrap_sel = (kind == REQ_READ) ? sample_wrap : wrap_ff;
   assign low_sel  = (kind == REQ_READ) ? in_word.counter_sample : last_ff;

   assign hi_prod = MULT_W'(wrap_sel) * MULT_W'(MS_PER_SEC);
   assign lo_prod = MULT_W'(low_sel) * MULT_W'(MS_PER_SEC);
   assign calc_ms = (TIME_W'(hi_prod) << HI_SHIFT)
                  + TIME_W'(lo_prod[MULT_W-1:TICK_SHIFT])
                  + base_ff;

   always_comb begin
      on_in   = on_ff;
      base_in = base_ff;
      wrap_in = wrap_ff;
      last_in = last_ff;
      time_in = '0;
      unique case (kind)
         REQ_SAMPLE: begin
            if (on_ff) begin
               wrap_in = sample_wrap;
               last_in = in_word.counter_sample;
            end
         end
         REQ_READ: begin
            if (on_ff) begin
               wrap_in = sample_wrap;
               last_in = in_word.counter_sample;
               time_in = calc_ms;
            end else begin
               time_in = '1;
            end
         end
         REQ_SET: begin
            base_in = in_word.new_time;
            wrap_in = '0;
            last_in = '0;
            on_in   = 1'b1;
         end
         REQ_DISABLE: begin
            on_in = 1'b0;
         end
         REQ_RESTORE: begin
            if (on_ff) begin
               base_in = calc_ms;
               wrap_in = '0;
               last_in = '0;
               time_in = calc_ms;
            end else begin
               time_in = '1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff    <= 1'b0;
         base_ff  <= '0;
         wrap_ff  <= '0;
         last_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            on_ff   <= on_in;
            base_ff <= base_in;
            wrap_ff <= wrap_in;
            last_ff <= last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         time_ff    <= time_in;
         enabled_ff <= on_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_time_ms = time_ff;
   assign out_enabled = enabled_ff;

endmodule

[sv/rtc_extended_millisecond_clock.sv]
// ----------------------------------------------------------------------------
// rtc_extended_millisecond_clock
// 64-bit millisecond wall clock on a free-running 32768 Hz tick counter
// ----------------------------------------------------------------------------
// path: request word -> input register -> core response register -> response word
// throughput: one word per cycle while rsp_chan.ready, set by the combinational
// state update loop in the core (compare, bump, multiply by 1000, add base)
// reset: synchronous, active high; clears enable, base, high word, last count
// and both stage valid flags
// ----------------------------------------------------------------------------
module rtc_extended_millisecond_clock
   import rtcms_pkg::*;
   (
   input  logic        clock,
   input  logic        reset,
   rtcms_req_if.sink   req_chan,
   rtcms_rsp_if.source rsp_chan
   );

   // request word as one bundle
   req_word_type req_word;
   // between input register and core
   req_word_type stage_word;
   logic         stage_valid;
   logic         stage_ready;

   assign req_word.req_type       = req_chan.req_type;
   assign req_word.counter_sample = req_chan.counter_sample;
   assign req_word.new_time       = req_chan.new_time;

   // input register: decouples the request side from the core
   rtcms_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_word   (req_word),
      .out_valid (stage_valid),
      .out_ready (stage_ready),
      .out_word  (stage_word)
   );

   // core: updates the clock state and registers the response word,
   // so a new word is taken only once the finished one is taken or none waits
   rtcms_core u_core (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (stage_valid),
      .in_ready    (stage_ready),
      .in_word     (stage_word),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .out_time_ms (rsp_chan.time_ms),
      .out_enabled (rsp_chan.enabled)
   );

endmodule
